>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/edb_pkg.sv
// Types, constants and register codes of the encoder detent and button block.
`default_nettype none

package edb_pkg;

  localparam int unsigned TIME_BITS    = 48;
  localparam int unsigned COUNT_W      = 32;
  // The detent size must be a power of two; it is set by its shift.
  localparam int unsigned DETENT_SHIFT = 2;
  localparam int unsigned COUNTS_PER_DETENT = 1 << DETENT_SHIFT;
  localparam int unsigned REM_W        = DETENT_SHIFT + 1;
  localparam int unsigned SUM_W        = COUNT_W + 2;
  localparam int unsigned STEPS_W      = 30;
  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

  localparam int unsigned DEB_MS_W     = 10;
  localparam int unsigned LONG_MS_W    = 16;
  localparam int unsigned DEB_US_W     = 20;
  localparam int unsigned THR_US_W     = 26;
  localparam int unsigned US_PER_MS    = 1000;
  localparam int unsigned DEFAULT_LONG_PRESS_MS = 800;
  localparam int unsigned DEFAULT_DEBOUNCE_MS   = 25;

  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_INVERT     = 3'd0;
  localparam logic [2:0] REG_ACTIVE_LOW = 3'd1;
  localparam logic [2:0] REG_SW_EN      = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS = 3'd4;

  typedef enum logic [1:0] {
    EV_CW    = 2'd0,
    EV_CCW   = 2'd1,
    EV_SHORT = 2'd2,
    EV_LONG  = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic                invert;
    logic                active_low;
    logic                sw_en;
    logic [DEB_US_W-1:0] deb_us;
    logic [THR_US_W-1:0] thr_us;
  } edb_cfg_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] counter_value;
    logic                      counter_valid;
    logic                      switch_level;
    logic [TIME_BITS-1:0]      time_us;
  } edb_item_t;

  typedef struct packed {
    logic               rot_v;
    event_kind_e        rot_kind;
    logic [STEPS_W-1:0] rot_steps;
    logic               press_v;
    event_kind_e        press_kind;
    logic               switch_down;
  } edb_res_t;

endpackage

`default_nettype wire

>>> rtl/core/edb_core.sv
// Per-item detent conversion and switch debounce, with the tracking state.
`default_nettype none

module edb_core
  import edb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  edb_item_t      item_i,
  input  edb_cfg_t       cfg_i,
  output edb_res_t       res_o
);

  logic [COUNT_W-1:0]   prev_q, prev_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 stable_q, stable_d;
  logic                 raw_prev_q, raw_prev_d;
  logic [TIME_BITS-1:0] raw_change_q, raw_change_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic                 fired_q, fired_d;

  logic [COUNT_W-1:0]      delta;
  logic signed [COUNT_W:0] dv;
  logic signed [SUM_W-1:0] sum_s;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [SUM_W-1:0] det;
  logic signed [SUM_W-1:0] rem_full;
  logic [SUM_W-1:0]        mag;
  logic                    rot_fire;

  logic                 press_now;
  logic                 raw_changed;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic                 deb_ok;
  logic                 short_ev;
  logic                 long_ev;

  // Rotation: wrapping delta, optional negation, truncating division.
  always_comb begin
    delta    = item_i.counter_value - prev_q;
    dv       = $signed({delta[COUNT_W-1], delta});
    if (cfg_i.invert) begin
      dv = -dv;
    end
    sum_s    = $signed({{(SUM_W-REM_W){rem_q[REM_W-1]}}, rem_q})
             + $signed({dv[COUNT_W], dv});
    // Bias negative sums so the arithmetic shift truncates toward zero.
    sum_adj  = sum_s[SUM_W-1] ? sum_s + $signed(SUM_W'(COUNTS_PER_DETENT - 1)) : sum_s;
    det      = sum_adj >>> DETENT_SHIFT;
    rem_full = sum_s - (det <<< DETENT_SHIFT);
    mag      = det[SUM_W-1] ? SUM_W'(-det) : SUM_W'(det);
    rot_fire = item_i.counter_valid && (delta != '0) && (det != '0);
  end

  // Switch debounce and press detection.
  always_comb begin
    press_now    = cfg_i.active_low ? !item_i.switch_level : item_i.switch_level;
    raw_changed  = press_now != raw_prev_q;
    since_change = item_i.time_us - raw_change_q;
    since_press  = item_i.time_us - press_start_q;
    deb_ok       = cfg_i.sw_en && !raw_changed && (press_now != stable_q) &&
                   (since_change >= TIME_BITS'(cfg_i.deb_us));
    short_ev     = deb_ok && !press_now && !fired_q;
    // A press accepted by this item starts at this time, so it cannot fire yet.
    long_ev      = cfg_i.sw_en && stable_q && !deb_ok && !fired_q &&
                   (since_press >= TIME_BITS'(cfg_i.thr_us));
  end

  always_comb begin
    prev_d        = prev_q;
    rem_d         = rem_q;
    stable_d      = stable_q;
    raw_prev_d    = raw_prev_q;
    raw_change_d  = raw_change_q;
    press_start_d = press_start_q;
    fired_d       = fired_q;

    if (item_i.counter_valid) begin
      prev_d = item_i.counter_value;
      if (delta != '0) begin
        rem_d = rem_full[REM_W-1:0];
      end
    end

    if (cfg_i.sw_en) begin
      if (raw_changed) begin
        raw_prev_d   = press_now;
        raw_change_d = item_i.time_us;
      end
      if (deb_ok) begin
        stable_d = press_now;
        if (press_now) begin
          press_start_d = item_i.time_us;
          fired_d       = 1'b0;
        end
      end
      if (long_ev) begin
        fired_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.rot_v       = rot_fire;
    res_o.rot_kind    = det[SUM_W-1] ? EV_CCW : EV_CW;
    res_o.rot_steps   = (mag > SUM_W'(STEPS_MAX)) ? STEPS_MAX : mag[STEPS_W-1:0];
    res_o.press_v     = short_ev || long_ev;
    res_o.press_kind  = long_ev ? EV_LONG : EV_SHORT;
    res_o.switch_down = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= '0;
      rem_q         <= '0;
      stable_q      <= 1'b0;
      raw_prev_q    <= 1'b0;
      raw_change_q  <= '0;
      press_start_q <= '0;
      fired_q       <= 1'b0;
    end else if (fire_i) begin
      prev_q        <= prev_d;
      rem_q         <= rem_d;
      stable_q      <= stable_d;
      raw_prev_q    <= raw_prev_d;
      raw_change_q  <= raw_change_d;
      press_start_q <= press_start_d;
      fired_q       <= fired_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/encoder_detent_and_button_press.sv
// An accepted item waits in the input register; once the result buffer is free, its results
// are registered there and offered, a rotation result first and then a press result.
// Throughput: one item per cycle while each item gives at most one result and the receiver
// is ready; an item with two results holds the one-item result buffer until both are taken.
// Reset clears the tracking state, the stream valids and loads the register defaults.
`default_nettype none

module encoder_detent_and_button_press
  import edb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input stream.
  input  wire logic              s_axis_tvalid_i,
  output      logic              s_axis_tready_o,
  // tdata: counter_value [31:0], switch_level [32], time_us [80:33], zero [87:81].
  input  wire logic [87:0]       s_axis_tdata_i,
  // tuser: counter_valid [0].
  input  wire logic [0:0]        s_axis_tuser_i,
  // Result stream.
  output      logic              m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // tdata: steps [29:0], switch_down [30], zero [31].
  output      logic [31:0]       m_axis_tdata_o,
  // tuser: event_kind [1:0].
  output      logic [1:0]        m_axis_tuser_o,
  output      logic              m_axis_tlast_o,
  // Configuration port.
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [ADDR_W-1:0] paddr_i,
  input  wire logic [DATA_W-1:0] pwdata_i,
  output      logic [DATA_W-1:0] prdata_o,
  output      logic              pready_o
);

  // Configuration registers, with the time thresholds kept in milliseconds for readback and in microseconds.
  logic                 invert_q, active_low_q, sw_en_q;
  logic [DEB_MS_W-1:0]  deb_ms_q;
  logic [LONG_MS_W-1:0] long_ms_q;
  logic [DEB_US_W-1:0]  deb_us_q;
  logic [THR_US_W-1:0]  thr_us_q;
  logic                 cfg_wr;
  edb_cfg_t             cfg;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q     <= 1'b0;
      active_low_q <= 1'b1;
      sw_en_q      <= 1'b1;
      deb_ms_q     <= DEB_MS_W'(DEFAULT_DEBOUNCE_MS);
      long_ms_q    <= '0;
      deb_us_q     <= DEB_US_W'(DEFAULT_DEBOUNCE_MS * US_PER_MS);
      thr_us_q     <= THR_US_W'(DEFAULT_LONG_PRESS_MS * US_PER_MS);
    end else if (cfg_wr) begin
      unique case (paddr_i[4:2])
        REG_INVERT:     invert_q     <= pwdata_i[0];
        REG_ACTIVE_LOW: active_low_q <= pwdata_i[0];
        REG_SW_EN:      sw_en_q      <= pwdata_i[0];
        REG_DEBOUNCE: begin
          deb_ms_q <= pwdata_i[DEB_MS_W-1:0];
          deb_us_q <= DEB_US_W'(pwdata_i[DEB_MS_W-1:0] * US_PER_MS);
        end
        REG_LONG_PRESS: begin
          long_ms_q <= pwdata_i[LONG_MS_W-1:0];
          if (pwdata_i[LONG_MS_W-1:0] == '0) begin
            thr_us_q <= THR_US_W'(DEFAULT_LONG_PRESS_MS * US_PER_MS);
          end else begin
            thr_us_q <= THR_US_W'(pwdata_i[LONG_MS_W-1:0] * US_PER_MS);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      REG_INVERT:     prdata_o = DATA_W'(invert_q);
      REG_ACTIVE_LOW: prdata_o = DATA_W'(active_low_q);
      REG_SW_EN:      prdata_o = DATA_W'(sw_en_q);
      REG_DEBOUNCE:   prdata_o = DATA_W'(deb_ms_q);
      REG_LONG_PRESS: prdata_o = DATA_W'(long_ms_q);
      default:        prdata_o = '0;
    endcase
  end

  assign cfg.invert     = invert_q;
  assign cfg.active_low = active_low_q;
  assign cfg.sw_en      = sw_en_q;
  assign cfg.deb_us     = deb_us_q;
  assign cfg.thr_us     = thr_us_q;

  // Input register.
  logic      in_v_q;
  edb_item_t in_q;
  logic      fire;
  logic      buf_free;
  logic      out_hs;
  edb_res_t  res;

  // Result buffer: a rotation entry shown first, then a press entry.
  logic               rot_v_q, press_v_q;
  logic [STEPS_W-1:0] rot_steps_q;
  event_kind_e        rot_kind_q, press_kind_q;
  logic               sw_down_q;

  assign out_hs   = m_axis_tvalid_o && m_axis_tready_i;
  assign buf_free = !(rot_v_q || press_v_q) || (out_hs && (rot_v_q ^ press_v_q));
  assign fire     = in_v_q && buf_free;
  assign s_axis_tready_o = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.counter_value <= $signed(s_axis_tdata_i[31:0]);
      in_q.counter_valid <= s_axis_tuser_i[0];
      in_q.switch_level  <= s_axis_tdata_i[32];
      in_q.time_us       <= s_axis_tdata_i[80:33];
    end
  end

  edb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_v_q   <= 1'b0;
      press_v_q <= 1'b0;
    end else if (fire) begin
      rot_v_q   <= res.rot_v;
      press_v_q <= res.press_v;
    end else if (out_hs) begin
      if (rot_v_q) begin
        rot_v_q <= 1'b0;
      end else begin
        press_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rot_steps_q  <= res.rot_steps;
      rot_kind_q   <= res.rot_kind;
      press_kind_q <= res.press_kind;
      sw_down_q    <= res.switch_down;
    end
  end

  always_comb begin
    m_axis_tvalid_o = rot_v_q || press_v_q;
    m_axis_tlast_o  = !(rot_v_q && press_v_q);
    if (rot_v_q) begin
      m_axis_tuser_o = rot_kind_q;
      m_axis_tdata_o = {1'b0, sw_down_q, rot_steps_q};
    end else begin
      m_axis_tuser_o = press_kind_q;
      m_axis_tdata_o = {1'b0, sw_down_q, STEPS_W'(1)};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/edb_checker.sv
// Port-level assertions for the encoder detent and button block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module edb_checker
  import edb_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_i,
  input wire logic [1:0]  m_axis_tuser_i,
  input wire logic        m_axis_tlast_i
);

  // Press results always count one step.
  `ASSERT_IMPLIES(a_press_one_step,
    m_axis_tvalid_i && (m_axis_tuser_i == EV_SHORT || m_axis_tuser_i == EV_LONG),
    m_axis_tdata_i[29:0] == 30'd1, "press result with steps other than one")

  // Only a rotation can be followed by another result of the same item.
  `ASSERT_IMPLIES(a_first_is_rotation,
    m_axis_tvalid_i && !m_axis_tlast_i,
    m_axis_tuser_i == EV_CW || m_axis_tuser_i == EV_CCW,
    "non-final result is not a rotation")

  // After a non-final result is taken, the press result of that item follows.
  `ASSERT_IMPLIES(a_second_is_press,
    $past(m_axis_tvalid_i && m_axis_tready_i && !m_axis_tlast_i),
    m_axis_tvalid_i && m_axis_tlast_i &&
    (m_axis_tuser_i == EV_SHORT || m_axis_tuser_i == EV_LONG),
    "press result missing after a rotation result")

  // A stalled result holds.
  `ASSERT_NEXT(a_stall_holds,
    m_axis_tvalid_i && !m_axis_tready_i,
    m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) &&
    $stable(m_axis_tlast_i), "stalled result changed")

endmodule

bind encoder_detent_and_button_press edb_checker u_edb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire
